// ----- hdl/m3i_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants and types for the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ELEM_W        = 32;
    localparam int COF_W         = 64;
    localparam int DET_W         = 98;
    localparam int NUM_EL        = 9;
    localparam int IDX_W         = 4;
    localparam int LAST_IDX      = 8;
    localparam int QBITS         = 33;
    localparam int QDEPTH        = 4;

    // cofactor j = m[COF_IDX[j][0]] * m[COF_IDX[j][1]] - m[COF_IDX[j][2]] * m[COF_IDX[j][3]]
    localparam logic [IDX_W-1:0] COF_IDX [NUM_EL][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd7, 4'd2, 4'd8, 4'd1},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd8, 4'd0, 4'd6, 4'd2},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd6, 4'd1, 4'd7, 4'd0},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef logic [NUM_EL-1:0][ELEM_W-1:0] t_mat;

    typedef struct packed {
        logic [NUM_EL-1:0][COF_W-1:0] cof;
        logic [DET_W-1:0]             det;
    } t_job;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic              zero;
        logic              sat;
        logic [ELEM_W-1:0] value;
    } t_qres;

endpackage

// ----- hdl/matrix3x3_inverse_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Inverse of a signed Q16.16 3x3 matrix by the adjugate method.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine elements on i_m_* and raise start; the item is taken at a
//   rising edge where start is high and busy is low.
//   The inverse appears on o_inv_* with o_singular and o_saturated for one
//   cycle, marked by o_valid. The receiver cannot stall; results are never
//   held back.
//   A five-stage front pipeline builds cofactors and determinant, a four-entry
//   queue decouples it from the back end, which feeds one quotient per cycle
//   into a shared divider of 35 pipeline stages while it holds a job.
//   The single divider takes the nine quotients of an item in turn, and the
//   back end pops a new item only when idle or as it issues the last
//   quotient of the current one; short bursts of up to four items are taken
//   on consecutive cycles.
//   Reset (synchronous, active low) empties the pipeline and queue; no
//   result is lost or produced by it other than items in flight being dropped.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_m_r0c0,
    input  logic [31:0] i_m_r0c1,
    input  logic [31:0] i_m_r0c2,
    input  logic [31:0] i_m_r1c0,
    input  logic [31:0] i_m_r1c1,
    input  logic [31:0] i_m_r1c2,
    input  logic [31:0] i_m_r2c0,
    input  logic [31:0] i_m_r2c1,
    input  logic [31:0] i_m_r2c2,
    output logic [31:0] o_inv_r0c0,
    output logic [31:0] o_inv_r0c1,
    output logic [31:0] o_inv_r0c2,
    output logic [31:0] o_inv_r1c0,
    output logic [31:0] o_inv_r1c1,
    output logic [31:0] o_inv_r1c2,
    output logic [31:0] o_inv_r2c0,
    output logic [31:0] o_inv_r2c1,
    output logic [31:0] o_inv_r2c2,
    output logic        o_singular,
    output logic        o_saturated,
    output logic        o_valid
);
    import m3i_pkg::*;

    t_mat mat, inv;
    t_job push_job, head_job;
    logic push, pop, empty;

    assign mat[0] = i_m_r0c0;
    assign mat[1] = i_m_r0c1;
    assign mat[2] = i_m_r0c2;
    assign mat[3] = i_m_r1c0;
    assign mat[4] = i_m_r1c1;
    assign mat[5] = i_m_r1c2;
    assign mat[6] = i_m_r2c0;
    assign mat[7] = i_m_r2c1;
    assign mat[8] = i_m_r2c2;

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_mat   (mat),
        .i_pop   (pop),
        .o_push  (push),
        .o_job   (push_job)
    );

    m3i_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (head_job)
    );

    m3i_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_inv       (inv),
        .o_singular  (o_singular),
        .o_saturated (o_saturated),
        .o_valid     (o_valid)
    );

    assign o_inv_r0c0 = inv[0];
    assign o_inv_r0c1 = inv[1];
    assign o_inv_r0c2 = inv[2];
    assign o_inv_r1c0 = inv[3];
    assign o_inv_r1c1 = inv[4];
    assign o_inv_r1c2 = inv[5];
    assign o_inv_r2c0 = inv[6];
    assign o_inv_r2c1 = inv[7];
    assign o_inv_r2c2 = inv[8];

endmodule

// ----- hdl/m3i_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_front
// Accepts matrices, computes the nine cofactors and the determinant in a
// five-stage pipeline and pushes each job to the queue. A credit count
// covering the pipeline and the queue drives busy.
// ----------------------------------------------------------------------------
module m3i_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  m3i_pkg::t_mat i_mat,
    input  logic          i_pop,
    output logic          o_push,
    output m3i_pkg::t_job o_job
);
    import m3i_pkg::*;

    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic                     accept;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic                     r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [COF_W-1:0]  r1_pa [NUM_EL];
    logic signed [COF_W-1:0]  r1_pb [NUM_EL];
    logic signed [ELEM_W-1:0] r1_abc [3];
    logic signed [ELEM_W-1:0] r2_abc [3];
    logic [NUM_EL-1:0][COF_W-1:0] r2_cof, r3_cof, r4_cof, r5_cof;
    logic signed [COF_W-1:0]  r3_hp [3];
    logic signed [COF_W:0]    r3_lp [3];
    logic signed [DET_W-1:0]  r4_t [3];
    logic [DET_W-1:0]         r5_det;

    assign accept = start && !busy;
    assign busy   = (r_cnt == CNT_W'(QDEPTH));

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!accept && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_v1  <= accept;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_EL; j++) begin
            r1_pa[j] <= $signed(i_mat[COF_IDX[j][0]]) * $signed(i_mat[COF_IDX[j][1]]);
            r1_pb[j] <= $signed(i_mat[COF_IDX[j][2]]) * $signed(i_mat[COF_IDX[j][3]]);
            r2_cof[j] <= COF_W'(r1_pa[j] - r1_pb[j]);
        end
        for (int t = 0; t < 3; t++) begin
            r1_abc[t] <= $signed(i_mat[t]);
            r2_abc[t] <= r1_abc[t];
            r3_hp[t]  <= r2_abc[t] * $signed(r2_cof[3*t][COF_W-1:32]);
            r3_lp[t]  <= r2_abc[t] * $signed({1'b0, r2_cof[3*t][31:0]});
            r4_t[t]   <= $signed({{2{r3_hp[t][COF_W-1]}}, r3_hp[t], 32'b0})
                       + $signed({{(DET_W-COF_W-1){r3_lp[t][COF_W]}}, r3_lp[t]});
        end
        r3_cof <= r2_cof;
        r4_cof <= r3_cof;
        r5_cof <= r4_cof;
        r5_det <= DET_W'(r4_t[0] + r4_t[1] + r4_t[2]);
    end

    assign o_push    = r_v5;
    assign o_job.cof = r5_cof;
    assign o_job.det = r5_det;

endmodule

// ----- hdl/m3i_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_queue
// Small register queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module m3i_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  m3i_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_empty,
    output m3i_pkg::t_job o_job
);
    import m3i_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= PTR_W'((CNT_W+1)'(r_wp) + 1'b1 == (CNT_W+1)'(QDEPTH) ? 0 : r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= PTR_W'((CNT_W+1)'(r_rp) + 1'b1 == (CNT_W+1)'(QDEPTH) ? 0 : r_rp + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- hdl/m3i_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_div
// Pipelined restoring divider: one range check stage, then one stage per
// quotient bit. Produces the saturated, signed 32-bit quotient.
// ----------------------------------------------------------------------------
module m3i_div #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [m3i_pkg::IDX_W-1:0]    i_idx,
    input  logic                         i_neg,
    input  logic                         i_zero,
    input  logic [64+2*FRAC_BITS-1:0]    i_num,
    input  logic [m3i_pkg::DET_W-1:0]    i_den,
    output m3i_pkg::t_qres               o_res
);
    import m3i_pkg::*;

    localparam int NW = 64 + 2 * FRAC_BITS;
    localparam int CW = DET_W + QBITS + 1;
    localparam int NS = QBITS + 1;

    logic [NW-1:0]     r_rem  [NS];
    logic [DET_W-1:0]  r_den  [NS];
    logic [QBITS-1:0]  r_q    [NS];
    logic              r_v    [NS];
    logic [IDX_W-1:0]  r_idx  [NS];
    logic              r_neg  [NS];
    logic              r_zero [NS];
    logic              r_sat  [NS];
    logic              r_ov;
    logic [IDX_W-1:0]  r_oidx;
    logic              r_ozero, r_osat;
    logic [ELEM_W-1:0] r_oval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_q[0]    <= '0;
        r_idx[0]  <= i_idx;
        r_neg[0]  <= i_neg;
        r_zero[0] <= i_zero;
        r_sat[0]  <= CW'(i_num) >= (CW'(i_den) << QBITS);
        for (int s = 1; s < NS; s++) begin
            r_den[s]  <= r_den[s-1];
            r_idx[s]  <= r_idx[s-1];
            r_neg[s]  <= r_neg[s-1];
            r_zero[s] <= r_zero[s-1];
            r_sat[s]  <= r_sat[s-1];
            if (CW'(r_rem[s-1]) >= (CW'(r_den[s-1]) << (QBITS - s))) begin
                r_rem[s] <= NW'(CW'(r_rem[s-1]) - (CW'(r_den[s-1]) << (QBITS - s)));
                r_q[s]   <= r_q[s-1] | (QBITS'(1) << (QBITS - s));
            end else begin
                r_rem[s] <= r_rem[s-1];
                r_q[s]   <= r_q[s-1];
            end
        end

        r_oidx  <= r_idx[NS-1];
        r_ozero <= r_zero[NS-1];
        if (r_zero[NS-1]) begin
            r_osat <= 1'b0;
            r_oval <= '0;
        end else if (r_neg[NS-1]) begin
            if (r_sat[NS-1] || r_q[NS-1] > QBITS'(33'h080000000)) begin
                r_osat <= 1'b1;
                r_oval <= 32'h80000000;
            end else begin
                r_osat <= 1'b0;
                r_oval <= ELEM_W'(-r_q[NS-1]);
            end
        end else begin
            if (r_sat[NS-1] || r_q[NS-1][QBITS-1] || r_q[NS-1][QBITS-2]) begin
                r_osat <= 1'b1;
                r_oval <= 32'h7FFFFFFF;
            end else begin
                r_osat <= 1'b0;
                r_oval <= r_q[NS-1][ELEM_W-1:0];
            end
        end
    end

    assign o_res = '{valid: r_ov, idx: r_oidx, zero: r_ozero, sat: r_osat, value: r_oval};

endmodule

// ----- hdl/m3i_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_back
// Pops jobs, issues one quotient per cycle into the shared divider while a
// job is active and gathers the nine elements into the result registers.
// ----------------------------------------------------------------------------
module m3i_back #(
    parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  m3i_pkg::t_job i_job,
    output logic          o_pop,
    output m3i_pkg::t_mat o_inv,
    output logic          o_singular,
    output logic          o_saturated,
    output logic          o_valid
);
    import m3i_pkg::*;

    localparam int NW = 64 + 2 * FRAC_BITS;

    t_job             r_cur;
    logic             r_act;
    logic [IDX_W-1:0] r_idx;
    logic             r_iv;
    logic [IDX_W-1:0] r_iidx;
    logic             r_ineg, r_izero;
    logic [NW-1:0]    r_inum;
    logic [DET_W-1:0] r_iden;
    logic             last;
    logic [COF_W-1:0] cof, cmag;
    logic             dneg;
    t_qres            res;
    t_mat             r_acc;
    t_mat             acc_full;
    logic             r_satacc;
    t_mat             r_inv;
    logic             r_sing, r_sat, r_val;

    assign last  = (r_idx == IDX_W'(LAST_IDX));
    assign o_pop = !i_empty && (!r_act || last);
    assign cof   = r_cur.cof[r_idx];
    assign cmag  = cof[COF_W-1] ? COF_W'(-cof) : cof;
    assign dneg  = r_cur.det[DET_W-1];

    always_comb begin
        acc_full           = r_acc;
        acc_full[LAST_IDX] = res.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
            r_iv  <= 1'b0;
            r_val <= 1'b0;
        end else begin
            r_iv  <= r_act;
            r_val <= res.valid && (res.idx == IDX_W'(LAST_IDX));
            if (o_pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (r_act) begin
                if (last) begin
                    r_act <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_job;
        end
        r_iidx  <= r_idx;
        r_ineg  <= cof[COF_W-1] ^ dneg;
        r_izero <= (r_cur.det == '0);
        r_inum  <= {cmag, {(2*FRAC_BITS){1'b0}}};
        r_iden  <= dneg ? DET_W'(-r_cur.det) : r_cur.det;
        if (res.valid) begin
            r_acc[res.idx] <= res.value;
            r_satacc <= (res.idx == '0) ? res.sat : (r_satacc | res.sat);
            if (res.idx == IDX_W'(LAST_IDX)) begin
                r_inv  <= acc_full;
                r_sing <= res.zero;
                r_sat  <= r_satacc | res.sat;
            end
        end
    end

    m3i_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_iv),
        .i_idx   (r_iidx),
        .i_neg   (r_ineg),
        .i_zero  (r_izero),
        .i_num   (r_inum),
        .i_den   (r_iden),
        .o_res   (res)
    );

    assign o_inv       = r_inv;
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;
    assign o_valid     = r_val;

endmodule
